// ----- rtl/core/pces_pkg.sv -----
// Shared types and constants for the pairwise Coulomb energy block.
`default_nettype none
package pces_pkg;

   // Action codes carried by an input transfer.
   localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
   localparam logic [1:0] ACT_COMPUTE     = 2'd2;

   // Shared divider geometry.
   localparam int DIV_W  = 56;
   localparam int DVS_W  = 24;
   localparam int ITER_W = 6;

   // Pair arithmetic constants.
   localparam int SQRT_STEPS = 21;
   localparam int TERM_ITERS = 35;
   localparam logic [41:0] CLOSE_D2 = 42'd262144;
   localparam logic [22:0] CLOSE_TERM = 23'd255744;
   localparam logic signed [11:0] COULOMB_K = 12'sd663;
   localparam logic signed [12:0] CHARGE_MIN = 13'sd11;
   localparam logic [14:0] DIEL_RESET = 15'd1024;

   typedef struct packed {
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
      logic signed [19:0] pos_z;
      logic signed [12:0] charge;
      logic               atom_on;
   } atom_type;

   typedef struct packed {
      logic     first;
      logic     second;
      atom_type atom;
   } wr_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
      logic [ITER_W-1:0] iters;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// ----- rtl/core/pces_if.sv -----
// Channel interfaces for requests, results and the dielectric register write.
`default_nettype none
interface pces_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [19:0] pos_x;
   logic signed [19:0] pos_y;
   logic signed [19:0] pos_z;
   logic signed [12:0] charge;
   logic               atom_on;
   modport source (output valid, action, pos_x, pos_y, pos_z, charge, atom_on, input ready);
   modport sink (input valid, action, pos_x, pos_y, pos_z, charge, atom_on, output ready);
endinterface

interface pces_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] energy;
   logic               saturated;
   logic               dropped;
   modport source (output valid, energy, saturated, dropped, input ready);
   modport sink (input valid, energy, saturated, dropped, output ready);
endinterface

interface pces_csr_if;
   logic        valid;
   logic        ready;
   logic [14:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pairwise_coulomb_energy_sum.sv -----
// Top level of the pairwise Coulomb energy block.
//
//  Channel   Direction  Transfer carries
//  req_chan  in         action, pos_x, pos_y, pos_z, charge, atom_on
//  rsp_chan  out        energy, saturated, dropped (one per compute)
//  csr_chan  in         dielectric_q8 write data
//
// A load is accepted only once the engine has finished reading the atom stores
// for every queued compute. A compute walks the pairs of the two sets: a close
// pair adds a fixed penalty, and every other pair that is not skipped runs the
// 21-step square root and the 35-step divider; a final divide scales the sum.
// Reset is synchronous and clears the set counts, the drop flag, the queue and
// the engine; the atom stores are not cleared. Up to two computes may wait in
// the queue while a result is held in the output register for the sink.
`default_nettype none
module pairwise_coulomb_energy_sum #(
   parameter int MAX_ATOMS = 64
) (
   input wire logic   clock,
   input wire logic   reset,
   pces_req_if.sink   req_chan,
   pces_rsp_if.source rsp_chan,
   pces_csr_if.sink   csr_chan
);
   import pces_pkg::*;

   localparam int CW = $clog2(MAX_ATOMS + 1);
   localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;

   // Dielectric register; a written zero is treated as one.
   logic [14:0] diel_ff, diel_in, diel_eff;

   wr_type          wr;
   logic [AW-1:0]   wr_addr;
   logic            cmd_push, cmd_pop, cmd_full, cmd_pending, engine_busy;
   logic [2*CW:0]   cmd_in_data, cmd_out_data;
   div_req_type     div_req;
   div_rsp_type     div_rsp;

   assign csr_chan.ready = 1'b1;
   assign diel_in  = (csr_chan.valid && csr_chan.ready) ? csr_chan.data : diel_ff;
   assign diel_eff = (diel_ff == '0) ? 15'd1 : diel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         diel_ff <= DIEL_RESET;
      end else begin
         diel_ff <= diel_in;
      end
   end

   // The front classifies each transfer and writes atoms straight into the
   // engine's stores; computes travel through the queue.
   pces_front #(.MAX_ATOMS(MAX_ATOMS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .engine_busy (engine_busy),
      .cmd_full    (cmd_full),
      .cmd_pending (cmd_pending),
      .wr          (wr),
      .wr_addr     (wr_addr),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_in_data)
   );

   pces_cmd_fifo #(.W(2 * CW + 1)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .not_empty (cmd_pending)
   );

   pces_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // The engine owns the atom stores, the pair walk and the output register.
   pces_engine #(.MAX_ATOMS(MAX_ATOMS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .wr_addr   (wr_addr),
      .cmd_valid (cmd_pending),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .diel      (diel_eff),
      .busy      (engine_busy),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp       (rsp_chan)
   );
endmodule
`default_nettype wire

// ----- rtl/core/pces_cmd_fifo.sv -----
// Two-entry queue carrying compute commands from the front to the engine.
`default_nettype none
module pces_cmd_fifo #(
   parameter int W = 15
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] push_data,
   output logic              full,
   input  wire logic         pop,
   output logic [W-1:0]      pop_data,
   output logic              not_empty
);
   logic [W-1:0] slot_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   cnt_ff;
   logic         wr_ptr_in, rd_ptr_in;
   logic [1:0]   cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/pces_front.sv -----
// Front end: takes request transfers, writes atoms and queues compute commands.
`default_nettype none
module pces_front #(
   parameter int MAX_ATOMS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   pces_req_if.sink                  req,
   input  wire logic                 engine_busy,
   input  wire logic                 cmd_full,
   input  wire logic                 cmd_pending,
   output pces_pkg::wr_type          wr,
   output logic [((MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1)-1:0] wr_addr,
   output logic                      cmd_push,
   output logic [2*$clog2(MAX_ATOMS+1):0] cmd_data
);
   import pces_pkg::*;

   localparam int CW = $clog2(MAX_ATOMS + 1);
   localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ATOMS);

   logic [CW-1:0] first_cnt_ff, second_cnt_ff, first_cnt_in, second_cnt_in;
   logic          overflow_ff, overflow_in;
   logic          quiet, accept;

   // Loads wait until the engine no longer reads the atom stores.
   assign quiet = !engine_busy && !cmd_pending;

   always_comb begin
      case (req.action)
         ACT_LOAD_FIRST, ACT_LOAD_SECOND: req.ready = quiet;
         ACT_COMPUTE:                     req.ready = !cmd_full;
         default:                         req.ready = 1'b1;
      endcase
   end

   assign accept = req.valid && req.ready;

   always_comb begin
      first_cnt_in  = first_cnt_ff;
      second_cnt_in = second_cnt_ff;
      overflow_in   = overflow_ff;
      wr.first      = 1'b0;
      wr.second     = 1'b0;
      wr.atom       = '{pos_x: req.pos_x, pos_y: req.pos_y, pos_z: req.pos_z,
                        charge: req.charge, atom_on: req.atom_on};
      wr_addr       = (req.action == ACT_LOAD_SECOND) ? second_cnt_ff[AW-1:0]
                                                      : first_cnt_ff[AW-1:0];
      cmd_push      = 1'b0;
      cmd_data      = {overflow_ff, first_cnt_ff, second_cnt_ff};
      if (accept) begin
         unique case (req.action)
            ACT_LOAD_FIRST: begin
               if (first_cnt_ff == FULL_CNT) begin
                  overflow_in = 1'b1;
               end else begin
                  wr.first     = 1'b1;
                  first_cnt_in = first_cnt_ff + 1'b1;
               end
            end
            ACT_LOAD_SECOND: begin
               if (second_cnt_ff == FULL_CNT) begin
                  overflow_in = 1'b1;
               end else begin
                  wr.second     = 1'b1;
                  second_cnt_in = second_cnt_ff + 1'b1;
               end
            end
            ACT_COMPUTE: begin
               cmd_push      = 1'b1;
               first_cnt_in  = '0;
               second_cnt_in = '0;
               overflow_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_cnt_ff  <= '0;
         second_cnt_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         first_cnt_ff  <= first_cnt_in;
         second_cnt_ff <= second_cnt_in;
         overflow_ff   <= overflow_in;
      end
   end

   a_wr_idle: assert property (@(posedge clock) disable iff (reset)
      (wr.first || wr.second) |-> !engine_busy)
      else $error("atom write while engine reads the stores");
   a_wr_room: assert property (@(posedge clock) disable iff (reset)
      wr.first |-> (first_cnt_ff < FULL_CNT))
      else $error("atom write beyond first set capacity");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("compute pushed into a full queue");
endmodule
`default_nettype wire

// ----- rtl/core/pces_divider.sv -----
// Restoring divider, one quotient bit per cycle, shared by pair terms and scaling.
`default_nettype none
module pces_divider (
   input  wire logic          clock,
   input  wire logic          reset,
   input  pces_pkg::div_req_type req,
   output pces_pkg::div_rsp_type rsp
);
   import pces_pkg::*;

   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in, quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in, rem_ff, rem_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    rem_sh;
   logic              fits;

   assign rem_sh = {rem_ff, dvd_ff[DIV_W-1]};
   assign fits   = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (req.start) begin
         cnt_in = req.iters;
         dvd_in = req.dividend;
         dvs_in = req.divisor;
         rem_in = '0;
         quo_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         dvd_in  = {dvd_ff[DIV_W-2:0], 1'b0};
         rem_in  = fits ? DVS_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DVS_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         done_in = (cnt_ff == ITER_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

// ----- rtl/core/pces_engine.sv -----
// Back end: walks the pair grid, sums the terms and scales the total.
`default_nettype none
module pces_engine #(
   parameter int MAX_ATOMS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  pces_pkg::wr_type          wr,
   input  wire logic [((MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1)-1:0] wr_addr,
   input  wire logic                 cmd_valid,
   input  wire logic [2*$clog2(MAX_ATOMS+1):0] cmd_data,
   output logic                      cmd_pop,
   input  wire logic [14:0]          diel,
   output logic                      busy,
   output pces_pkg::div_req_type     div_req,
   input  pces_pkg::div_rsp_type     div_rsp,
   pces_rsp_if.source                rsp
);
   import pces_pkg::*;

   localparam int CW    = $clog2(MAX_ATOMS + 1);
   localparam int AW    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int SUM_W = 24 + 2 * CW;

   typedef enum logic [3:0] {
      S_IDLE, S_RDA, S_CHKA, S_RDB, S_CHKB, S_SUM, S_TEST, S_SQRT,
      S_DIVT, S_WAITT, S_FIN, S_WAITF, S_PUSH
   } state_type;

   atom_type first_mem [MAX_ATOMS];
   atom_type second_mem [MAX_ATOMS];
   atom_type a_rd_ff, b_rd_ff;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             i_ff, i_in, j_ff, j_in, fc_ff, fc_in, sc_ff, sc_in;
   logic                      drop_ff, drop_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [41:0]               sqx_ff, sqx_in, sqy_ff, sqy_in, sqz_ff, sqz_in;
   logic [41:0]               d2_ff, d2_in, sdata_ff, sdata_in;
   logic signed [25:0]        prod_ff, prod_in;
   logic signed [35:0]        p663_ff, p663_in;
   logic [23:0]               rem_ff, rem_in;
   logic [20:0]               root_ff, root_in;
   logic [4:0]                scnt_ff, scnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]        energy_ff, energy_in;
   logic                      sat_ff, sat_in, dropped_ff, dropped_in;

   logic signed [20:0]        dx, dy, dz;
   logic signed [41:0]        sx, sy, sz;
   logic [23:0]               rem_sh, trial;
   logic [35:0]               p_abs;
   logic [34:0]               term_mag;
   logic [22:0]               term_q;
   logic signed [SUM_W-1:0]   term;
   logic [SUM_W-1:0]          sum_abs;
   logic [DIV_W-1:0]          q;

   function automatic logic atom_skip(atom_type a);
      return !a.atom_on || (a.charge < CHARGE_MIN && a.charge > -CHARGE_MIN);
   endfunction

   always_ff @(posedge clock) begin
      if (wr.first) begin
         first_mem[wr_addr] <= wr.atom;
      end
      if (wr.second) begin
         second_mem[wr_addr] <= wr.atom;
      end
      a_rd_ff <= first_mem[i_ff[AW-1:0]];
      b_rd_ff <= second_mem[j_ff[AW-1:0]];
   end

   assign dx = 21'(a_rd_ff.pos_x) - 21'(b_rd_ff.pos_x);
   assign dy = 21'(a_rd_ff.pos_y) - 21'(b_rd_ff.pos_y);
   assign dz = 21'(a_rd_ff.pos_z) - 21'(b_rd_ff.pos_z);
   assign sx = dx * dx;
   assign sy = dy * dy;
   assign sz = dz * dz;

   assign rem_sh   = {rem_ff[21:0], sdata_ff[41:40]};
   assign trial    = {1'b0, root_ff, 2'b01};
   assign p_abs    = p663_ff[35] ? $unsigned(-p663_ff) : $unsigned(p663_ff);
   assign term_mag = p_abs[34:0] + 35'({root_ff, 2'b00});
   assign q        = div_rsp.quotient;
   assign term_q   = q[22:0];
   assign term     = p663_ff[35] ? -$signed(SUM_W'(term_q)) : $signed(SUM_W'(term_q));
   assign sum_abs  = sum_ff[SUM_W-1] ? $unsigned(-sum_ff) : $unsigned(sum_ff);

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      fc_in        = fc_ff;
      sc_in        = sc_ff;
      drop_in      = drop_ff;
      sum_in       = sum_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      sqz_in       = sqz_ff;
      prod_in      = prod_ff;
      d2_in        = d2_ff;
      p663_in      = p663_ff;
      sdata_in     = sdata_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      scnt_in      = scnt_ff;
      energy_in    = energy_ff;
      sat_in       = sat_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      cmd_pop      = 1'b0;
      div_req      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               drop_in  = cmd_data[2*CW];
               fc_in    = cmd_data[2*CW-1:CW];
               sc_in    = cmd_data[CW-1:0];
               i_in     = '0;
               sum_in   = '0;
               state_in = S_RDA;
            end
         end
         S_RDA: state_in = S_CHKA;
         S_CHKA: begin
            if (i_ff >= fc_ff) begin
               state_in = S_FIN;
            end else if (atom_skip(a_rd_ff)) begin
               i_in     = i_ff + 1'b1;
               state_in = S_RDA;
            end else begin
               j_in     = '0;
               state_in = S_RDB;
            end
         end
         S_RDB: state_in = S_CHKB;
         S_CHKB: begin
            if (j_ff >= sc_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = S_RDA;
            end else if (atom_skip(b_rd_ff)) begin
               j_in     = j_ff + 1'b1;
               state_in = S_RDB;
            end else begin
               sqx_in   = $unsigned(sx);
               sqy_in   = $unsigned(sy);
               sqz_in   = $unsigned(sz);
               prod_in  = a_rd_ff.charge * b_rd_ff.charge;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            d2_in    = sqx_ff + sqy_ff + sqz_ff;
            p663_in  = prod_ff * COULOMB_K;
            state_in = S_TEST;
         end
         S_TEST: begin
            if (d2_ff < CLOSE_D2) begin
               sum_in   = sum_ff + $signed(SUM_W'(CLOSE_TERM));
               j_in     = j_ff + 1'b1;
               state_in = S_RDB;
            end else begin
               sdata_in = d2_ff;
               rem_in   = '0;
               root_in  = '0;
               scnt_in  = 5'(SQRT_STEPS);
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            sdata_in = {sdata_ff[39:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[19:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[19:0], 1'b0};
            end
            scnt_in = scnt_ff - 1'b1;
            if (scnt_ff == 5'd1) begin
               state_in = S_DIVT;
            end
         end
         S_DIVT: begin
            div_req.start    = 1'b1;
            div_req.dividend = {term_mag, (DIV_W - TERM_ITERS)'(0)};
            div_req.divisor  = {root_ff, 3'b000};
            div_req.iters    = ITER_W'(TERM_ITERS);
            state_in         = S_WAITT;
         end
         S_WAITT: begin
            if (div_rsp.done) begin
               sum_in   = sum_ff + term;
               j_in     = j_ff + 1'b1;
               state_in = S_RDB;
            end
         end
         S_FIN: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'({sum_abs, 8'h00}) + DIV_W'(diel[14:1]);
            div_req.divisor  = DVS_W'(diel);
            div_req.iters    = ITER_W'(DIV_W);
            state_in         = S_WAITF;
         end
         S_WAITF: begin
            if (div_rsp.done) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            // The quotient stays put in the divider, so the output register
            // is loaded only once the previous result has left.
            if (!rsp_valid_ff || rsp.ready) begin
               dropped_in = drop_ff;
               if (!sum_ff[SUM_W-1] && q > DIV_W'(32'h7FFF_FFFF)) begin
                  energy_in = 32'sh7FFF_FFFF;
                  sat_in    = 1'b1;
               end else if (sum_ff[SUM_W-1] && q > DIV_W'(33'h0_8000_0000)) begin
                  energy_in = 32'sh8000_0000;
                  sat_in    = 1'b1;
               end else begin
                  energy_in = sum_ff[SUM_W-1] ? $signed(32'd0 - q[31:0]) : $signed(q[31:0]);
                  sat_in    = 1'b0;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      fc_ff      <= fc_in;
      sc_ff      <= sc_in;
      drop_ff    <= drop_in;
      sum_ff     <= sum_in;
      sqx_ff     <= sqx_in;
      sqy_ff     <= sqy_in;
      sqz_ff     <= sqz_in;
      prod_ff    <= prod_in;
      d2_ff      <= d2_in;
      p663_ff    <= p663_in;
      sdata_ff   <= sdata_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      scnt_ff    <= scnt_in;
      energy_ff  <= energy_in;
      sat_ff     <= sat_in;
      dropped_ff <= dropped_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.energy    = energy_ff;
   assign rsp.saturated = sat_ff;
   assign rsp.dropped   = dropped_ff;

   a_i_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHKA) |-> (i_ff <= fc_ff))
      else $error("first index ran past the set count");
   a_j_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHKB) |-> (j_ff <= sc_ff))
      else $error("second index ran past the set count");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_WAITT || state_ff == S_WAITF))
      else $error("divider finished with nobody waiting");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_PUSH))
      else $error("result raised outside the push state");
endmodule
`default_nettype wire

// ----- tb/pairwise_coulomb_energy_sum_tb.sv -----
// Testbench for the pairwise Coulomb energy block: directed table, random atom sets, checks.
`default_nettype none
module pairwise_coulomb_energy_sum_tb;
   import pces_pkg::*;

   // One row of the directed table. Where typed is set, the expected result
   // is given by hand; otherwise it comes from the energy predictor.
   typedef struct {
      logic [1:0] act;
      int         x, y, z, q;
      bit         on;
      bit         typed;
      int         e;
      bit         s, d;
   } stim_row;

   typedef struct {
      logic signed [31:0] energy;
      logic               saturated;
      logic               dropped;
   } energy_result;

   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic clock;
   logic reset;

   pces_req_if req_bus ();
   pces_rsp_if rsp_bus ();
   pces_csr_if csr_bus ();

   pairwise_coulomb_energy_sum DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // The predictor's own copy of the two atom sets, their counts, the drop
   // flag and the dielectric register.
   atom_type    first_set [64];
   atom_type    second_set [64];
   int          first_n;
   int          second_n;
   bit          drop_flag;
   logic [14:0] diel_value;

   energy_result pending_energy [$];
   int           errors;
   int           idle_pct;
   int           stall_pct;
   int           load_total;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs; far beyond the slowest correct run.
   initial begin
      #40000000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   // Integer square root, rounded down, one result bit at a time.
   function automatic longint floor_root(input longint v);
      longint r;
      longint t;
      int     b;
      r = 0;
      for (b = 31; b >= 0; b--) begin
         t = r | (longint'(1) << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // Division with rounding to nearest, ties away from zero.
   function automatic longint round_div(input longint n, input longint d);
      longint mag;
      longint quo;
      mag = (n < 0) ? -n : n;
      quo = (mag + d / 2) / d;
      return (n < 0) ? -quo : quo;
   endfunction

   // Contribution of one pair in Q8 kcal/mol: a fixed penalty when the
   // atoms are closer than half an angstrom, the Coulomb term otherwise.
   function automatic longint pair_energy(input atom_type a, input atom_type b);
      longint dx, dy, dz, d2;
      dx = longint'(a.pos_x) - longint'(b.pos_x);
      dy = longint'(a.pos_y) - longint'(b.pos_y);
      dz = longint'(a.pos_z) - longint'(b.pos_z);
      d2 = dx * dx + dy * dy + dz * dz;
      if (d2 < longint'(CLOSE_D2)) return longint'(CLOSE_TERM);
      return round_div(663 * longint'(a.charge) * longint'(b.charge), 8 * floor_root(d2));
   endfunction

   function automatic bit atom_counts(input atom_type a);
      return a.atom_on && (a.charge >= CHARGE_MIN || a.charge <= -CHARGE_MIN);
   endfunction

   // Advances the predictor by one accepted transfer; returns 1 with the
   // expected result when the transfer is a compute.
   function automatic bit predict_energy(input logic [1:0] act, input atom_type a,
                                         output energy_result res);
      longint sum;
      longint e;
      longint dv;
      int     i, j;
      res = '{energy: 0, saturated: 0, dropped: 0};
      case (act)
         ACT_LOAD_FIRST: begin
            if (first_n >= 64) drop_flag = 1'b1;
            else begin
               first_set[first_n] = a;
               first_n++;
            end
            return 1'b0;
         end
         ACT_LOAD_SECOND: begin
            if (second_n >= 64) drop_flag = 1'b1;
            else begin
               second_set[second_n] = a;
               second_n++;
            end
            return 1'b0;
         end
         ACT_COMPUTE: begin
            sum = 0;
            for (i = 0; i < first_n; i++) begin
               if (atom_counts(first_set[i])) begin
                  for (j = 0; j < second_n; j++) begin
                     if (atom_counts(second_set[j]))
                        sum += pair_energy(first_set[i], second_set[j]);
                  end
               end
            end
            dv = (diel_value == 0) ? 1 : longint'(diel_value);
            e = round_div(sum * 256, dv);
            if (e > 64'sd2147483647) begin
               e = 64'sd2147483647;
               res.saturated = 1'b1;
            end
            if (e < -64'sd2147483648) begin
               e = -64'sd2147483648;
               res.saturated = 1'b1;
            end
            res.energy = e[31:0];
            res.dropped = drop_flag;
            first_n = 0;
            second_n = 0;
            drop_flag = 1'b0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Result side: the ready line stalls at the rate of the current phase, and
   // every transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      energy_result want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_energy.size() == 0) begin
            $display("result transfer with no compute outstanding");
            errors++;
         end else begin
            want = pending_energy.pop_front();
            if (rsp_bus.energy !== want.energy)
               report_mismatch("energy", rsp_bus.energy, want.energy);
            if (rsp_bus.saturated !== want.saturated)
               report_mismatch("saturated", rsp_bus.saturated, want.saturated);
            if (rsp_bus.dropped !== want.dropped)
               report_mismatch("dropped", rsp_bus.dropped, want.dropped);
         end
      end
   end

   // One transfer on the request channel. Valid is left high after the
   // transfer so that back-to-back items never lower and raise it in one step;
   // it drops only when the sender chooses to idle.
   task automatic send_atom(input logic [1:0] act, input atom_type a, input bit typed,
                            input energy_result typed_res);
      energy_result res;
      if ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.pos_x   <= a.pos_x;
      req_bus.pos_y   <= a.pos_y;
      req_bus.pos_z   <= a.pos_z;
      req_bus.charge  <= a.charge;
      req_bus.atom_on <= a.atom_on;
      do @(posedge clock); while (!req_bus.ready);
      if (act != ACT_UNUSED) load_total++;
      if (predict_energy(act, a, res)) pending_energy.push_back(typed ? typed_res : res);
   endtask

   // Waits until every compute has returned its result, then lets the engine
   // settle so that a trailing load cannot still be in flight.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_energy.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_dielectric(input logic [14:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      diel_value = v;
   endtask

   // Random atom: mostly clustered near a centre so that distances vary from
   // close contact upwards, sometimes anywhere in the coordinate range.
   function automatic atom_type random_atom(input int cx, input int cy, input int cz);
      atom_type a;
      if ($urandom_range(4) == 0) begin
         a.pos_x = $urandom;
         a.pos_y = $urandom;
         a.pos_z = $urandom;
      end else begin
         a.pos_x = cx + $signed($urandom_range(0, 8191)) - 4096;
         a.pos_y = cy + $signed($urandom_range(0, 8191)) - 4096;
         a.pos_z = cz + $signed($urandom_range(0, 8191)) - 4096;
      end
      if ($urandom_range(5) == 0) a.charge = $signed($urandom_range(0, 24)) - 12;
      else a.charge = $urandom;
      a.atom_on = ($urandom_range(9) != 0);
      return a;
   endfunction

   // Fills both sets with strongly charged atoms half an angstrom apart so
   // that the sum runs past the 32-bit range.
   task automatic send_saturating_sets(input int sign);
      atom_type     a;
      energy_result none;
      int           k;
      none = '{energy: 0, saturated: 0, dropped: 0};
      a = '{pos_x: 0, pos_y: 0, pos_z: 0, charge: 13'sd4095, atom_on: 1'b1};
      for (k = 0; k < 30; k++) send_atom(ACT_LOAD_FIRST, a, 1'b0, none);
      a.pos_x = 512;
      a.charge = (sign > 0) ? 13'sd4095 : -13'sd4096;
      for (k = 0; k < 30; k++) send_atom(ACT_LOAD_SECOND, a, 1'b0, none);
      send_atom(ACT_COMPUTE, a, 1'b0, none);
   endtask

   // Overfills one set while the other stays small, to exercise the drop flag.
   task automatic send_overfull(input logic [1:0] full_side);
      energy_result none;
      logic [1:0]   other;
      int           k;
      none = '{energy: 0, saturated: 0, dropped: 0};
      other = (full_side == ACT_LOAD_FIRST) ? ACT_LOAD_SECOND : ACT_LOAD_FIRST;
      for (k = 0; k < 67; k++) send_atom(full_side, random_atom(0, 0, 0), 1'b0, none);
      for (k = 0; k < 3; k++) send_atom(other, random_atom(0, 0, 0), 1'b0, none);
      send_atom(ACT_COMPUTE, random_atom(0, 0, 0), 1'b0, none);
   endtask

   initial begin
      stim_row      directed [];
      energy_result typed_res;
      energy_result none;
      atom_type     a;
      logic [14:0]  diel_plan [4];
      int           phase_idle [4];
      int           phase_stall [4];
      int           p, k, n1, n2, cx, cy, cz;
      logic [1:0]   act;

      none = '{energy: 0, saturated: 0, dropped: 0};
      errors = 0;
      load_total = 0;
      idle_pct = 0;
      stall_pct = 0;
      first_n = 0;
      second_n = 0;
      drop_flag = 1'b0;
      diel_value = DIEL_RESET;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_LOAD_FIRST;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      req_bus.charge = '0;
      req_bus.atom_on = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part, run at the reset dielectric of four.
      directed = '{
         // Empty sets straight after reset give zero.
         '{ACT_COMPUTE,      0,       0,       0,     0, 0, 1, 0,     0, 0},
         // Coordinate and charge extremes on both sides.
         '{ACT_LOAD_FIRST,  -524288,  524287,  0,     4095, 1, 0, 0, 0, 0},
         '{ACT_LOAD_SECOND,  524287, -524288, -524288, -4096, 1, 0, 0, 0, 0},
         '{ACT_LOAD_FIRST,   524287,  524287,  524287, -4096, 1, 0, 0, 0, 0},
         '{ACT_LOAD_SECOND, -524288, -524288,  524287, 4095, 1, 0, 0, 0, 0},
         '{ACT_COMPUTE,      0,       0,       0,     0, 0, 0, 0,     0, 0},
         // Charges just inside the skip threshold contribute nothing.
         '{ACT_LOAD_FIRST,   0,       0,       0,     10, 1, 0, 0,   0, 0},
         '{ACT_LOAD_SECOND,  5000,    0,       0,    -10, 1, 0, 0,   0, 0},
         '{ACT_COMPUTE,      0,       0,       0,     0, 0, 1, 0,     0, 0},
         // Charges just at the threshold do contribute.
         '{ACT_LOAD_FIRST,   0,       0,       0,     11, 1, 0, 0,   0, 0},
         '{ACT_LOAD_SECOND,  5000,    0,       0,    -11, 1, 0, 0,   0, 0},
         '{ACT_COMPUTE,      0,       0,       0,     0, 0, 0, 0,     0, 0},
         // An atom that is switched off is ignored.
         '{ACT_LOAD_FIRST,   0,       0,       0,   2000, 0, 0, 0,   0, 0},
         '{ACT_LOAD_SECOND,  3000,    0,       0,   2000, 1, 0, 0,   0, 0},
         '{ACT_COMPUTE,      0,       0,       0,     0, 0, 1, 0,     0, 0},
         // The unused action does nothing.
         '{ACT_UNUSED,       0,       0,       0,     0, 1, 0, 0,     0, 0},
         // A close pair adds the fixed penalty whatever the charges.
         '{ACT_LOAD_FIRST,   0,       0,       0,   1024, 1, 0, 0,   0, 0},
         '{ACT_LOAD_SECOND,  100,     0,       0,  -2000, 1, 0, 0,   0, 0},
         '{ACT_COMPUTE,      0,       0,       0,     0, 0, 1, 63936, 0, 0},
         // Exactly half an angstrom apart is no longer a close pair.
         '{ACT_LOAD_FIRST,   0,       0,       0,   1024, 1, 0, 0,   0, 0},
         '{ACT_LOAD_SECOND,  0,       512,     0,   1024, 1, 0, 0,   0, 0},
         '{ACT_COMPUTE,      0,       0,       0,     0, 0, 0, 0,     0, 0}
      };
      foreach (directed[r]) begin
         a.pos_x = directed[r].x;
         a.pos_y = directed[r].y;
         a.pos_z = directed[r].z;
         a.charge = directed[r].q;
         a.atom_on = directed[r].on;
         typed_res = '{energy: directed[r].e, saturated: directed[r].s,
                       dropped: directed[r].d};
         send_atom(directed[r].act, a, directed[r].typed, typed_res);
      end

      // Random part in four phases, each with its own dielectric and its own
      // mix of sender idling and receiver stalls. The lowest nonzero setting comes
      // first so that the saturating sets really clip.
      diel_plan = '{15'd256, 15'd25600, 15'd0, 15'h7FFF};
      phase_idle = '{0, 51, 0, 22};
      phase_stall = '{0, 0, 51, 22};
      for (p = 0; p < 4; p++) begin
         drain_results();
         write_dielectric(p == 3 && $urandom_range(1) ? 15'($urandom_range(256, 25600))
                                                      : diel_plan[p]);
         idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         if (p == 0) begin
            send_saturating_sets(1);
            // Hold the sender back until the long compute has reported.
            drain_results();
            send_saturating_sets(-1);
            send_overfull(ACT_LOAD_FIRST);
            send_overfull(ACT_LOAD_SECOND);
         end
         while (load_total < 200 + (p + 1) * 420) begin
            n1 = $urandom_range(0, 6);
            n2 = $urandom_range(0, 6);
            cx = $signed($urandom_range(0, 1048575)) - 524288;
            cy = $signed($urandom_range(0, 1048575)) - 524288;
            cz = $signed($urandom_range(0, 1048575)) - 524288;
            while (n1 + n2 > 0) begin
               if (n2 == 0 || (n1 > 0 && $urandom_range(1))) begin
                  act = ACT_LOAD_FIRST;
                  n1--;
               end else begin
                  act = ACT_LOAD_SECOND;
                  n2--;
               end
               if ($urandom_range(19) == 0) act = ACT_UNUSED;
               send_atom(act, random_atom(cx, cy, cz), 1'b0, none);
            end
            send_atom(ACT_COMPUTE, random_atom(cx, cy, cz), 1'b0, none);
         end
      end

      drain_results();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
